@@ hdl/plas_pkg.sv @@
`default_nettype none
package plas_pkg;

  localparam int unsigned AcosStages = 16;
  localparam int unsigned TableLen = 24;
  localparam int unsigned NumStages = (AcosStages < TableLen) ? AcosStages : TableLen;
  localparam int unsigned ZW = 20;
  localparam int unsigned XW = 36;
  localparam int unsigned SqW = 72;
  localparam int unsigned RtW = 36;

  localparam logic [2:0] RegLightX = 3'd0;
  localparam logic [2:0] RegLightY = 3'd1;
  localparam logic [2:0] RegLightZ = 3'd2;
  localparam logic [2:0] RegIntens = 3'd3;
  localparam logic [2:0] RegRed    = 3'd4;
  localparam logic [2:0] RegGreen  = 3'd5;
  localparam logic [2:0] RegBlue   = 3'd6;

  localparam logic signed [ZW-1:0] RightAngle = 20'sd65536;
  localparam logic signed [ZW-1:0] StraightAngle = 20'sd131072;

  function automatic logic signed [ZW-1:0] atan_tab(input int unsigned i);
    logic signed [ZW-1:0] r;
    case (i)
      0: r = 20'sd32768;
      1: r = 20'sd19344;
      2: r = 20'sd10221;
      3: r = 20'sd5188;
      4: r = 20'sd2604;
      5: r = 20'sd1303;
      6: r = 20'sd652;
      7: r = 20'sd326;
      8: r = 20'sd163;
      9: r = 20'sd81;
      10: r = 20'sd41;
      11: r = 20'sd20;
      12: r = 20'sd10;
      13: r = 20'sd5;
      14: r = 20'sd3;
      15: r = 20'sd1;
      16: r = 20'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

  typedef struct packed {
    logic        zero;
    logic [15:0] inten;
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
  } side_t;

endpackage
`default_nettype wire

@@ hdl/plas_isqrt.sv @@
`default_nettype none
// pipelined square root, one result bit per stage
module plas_isqrt (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      en_i,
  input  wire logic                      valid_i,
  input  wire logic [plas_pkg::SqW-1:0]  val_i,
  input  wire logic signed [plas_pkg::XW-1:0] x_i,
  input  wire plas_pkg::side_t           side_i,
  output logic                           valid_o,
  output logic [plas_pkg::RtW-1:0]       root_o,
  output logic signed [plas_pkg::XW-1:0] x_o,
  output plas_pkg::side_t                side_o
);
  localparam int unsigned N = plas_pkg::RtW;
  localparam int unsigned W = plas_pkg::SqW;

  logic [W-1:0] rem_q [N+1];
  logic [N-1:0] root_q [N+1];
  logic [N:0]   vld_q;
  logic signed [plas_pkg::XW-1:0] x_q [N+1];
  plas_pkg::side_t side_q [N+1];

  always_comb begin
    rem_q[0]  = val_i;
    root_q[0] = '0;
    vld_q[0]  = valid_i;
    x_q[0]    = x_i;
    side_q[0] = side_i;
  end

  for (genvar k = 0; k < N; k++) begin : g_st
    localparam int unsigned B = N - 1 - k;
    logic [W-1:0] trial;
    logic [N-1:0] root_d;
    logic [W-1:0] rem_d;
    logic [W+1:0] t2;
    always_comb begin
      t2 = ({{(W-N){1'b0}}, root_q[k]} << (B + 1)) + ({{(W+1){1'b0}}, 1'b1} << (2 * B));
      trial = t2[W-1:0];
      if (t2[W+1:W] == 2'b00 && rem_q[k] >= trial) begin
        rem_d  = rem_q[k] - trial;
        root_d = root_q[k] | (N'(1) << B);
      end else begin
        rem_d  = rem_q[k];
        root_d = root_q[k];
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[k+1] <= vld_q[k];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1]  <= rem_d;
        root_q[k+1] <= root_d;
        x_q[k+1]    <= x_q[k];
        side_q[k+1] <= side_q[k];
      end
    end
  end

  assign valid_o = vld_q[N];
  assign root_o  = root_q[N];
  assign x_o     = x_q[N];
  assign side_o  = side_q[N];
endmodule
`default_nettype wire

@@ hdl/plas_cordic.sv @@
`default_nettype none
module plas_cordic (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           en_i,
  input  wire logic                           valid_i,
  input  wire logic signed [plas_pkg::XW-1:0] x_i,
  input  wire logic [plas_pkg::RtW-1:0]       y_i,
  input  wire plas_pkg::side_t                side_i,
  output logic                                valid_o,
  output logic                                lit_o,
  output logic [15:0]                         inten_o,
  output plas_pkg::side_t                     side_o
);
  localparam int unsigned S = plas_pkg::NumStages;
  localparam int unsigned CW = plas_pkg::XW + 3;
  localparam int unsigned ZW = plas_pkg::ZW;

  logic signed [CW-1:0] x_q [S+1];
  logic signed [CW-1:0] y_q [S+1];
  logic signed [ZW-1:0] z_q [S+1];
  logic [S+1:0] vld_q;
  logic [S:0]   rt_q;
  plas_pkg::side_t side_q [S+2];

  logic signed [CW-1:0] x0, y0;
  logic signed [ZW-1:0] a_q;
  logic                 rt0;

  // pre-rotation into the right half-plane
  always_comb begin
    x0  = CW'(x_i);
    y0  = $signed({{(CW-plas_pkg::RtW){1'b0}}, y_i});
    rt0 = (x_i == '0) && (y_i == '0);
    if (x_i < 0) begin
      x_q[0] = y0;
      y_q[0] = -x0;
      z_q[0] = plas_pkg::RightAngle;
    end else begin
      x_q[0] = x0;
      y_q[0] = y0;
      z_q[0] = '0;
    end
    vld_q[0]  = valid_i;
    rt_q[0]   = rt0;
    side_q[0] = side_i;
  end

  for (genvar i = 0; i < S; i++) begin : g_st
    logic signed [CW-1:0] xd, yd;
    logic signed [ZW-1:0] zd;
    always_comb begin
      if (!y_q[i][CW-1]) begin
        xd = x_q[i] + (y_q[i] >>> i);
        yd = y_q[i] - (x_q[i] >>> i);
        zd = z_q[i] + plas_pkg::atan_tab(i);
      end else begin
        xd = x_q[i] - (y_q[i] >>> i);
        yd = y_q[i] + (x_q[i] >>> i);
        zd = z_q[i] - plas_pkg::atan_tab(i);
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[i+1] <= vld_q[i];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[i+1]    <= xd;
        y_q[i+1]    <= yd;
        z_q[i+1]    <= zd;
        rt_q[i+1]   <= rt_q[i];
        side_q[i+1] <= side_q[i];
      end
    end
  end

  // clamp and falloff
  logic signed [ZW-1:0] a_d;
  always_comb begin
    if (rt_q[S]) a_d = plas_pkg::RightAngle;
    else if (z_q[S] < 0) a_d = '0;
    else if (z_q[S] > plas_pkg::StraightAngle) a_d = plas_pkg::StraightAngle;
    else a_d = z_q[S];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[S+1] <= 1'b0;
    end else if (en_i) begin
      vld_q[S+1] <= vld_q[S];
    end
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q         <= a_d;
      side_q[S+1] <= side_q[S];
    end
  end

  logic [16:0] frac;
  logic [32:0] prod;
  logic        lit;
  always_comb begin
    lit  = (a_q <= plas_pkg::RightAngle) && !side_q[S+1].zero;
    frac = 17'(plas_pkg::RightAngle - a_q);
    prod = side_q[S+1].inten * frac;
  end

  assign valid_o = vld_q[S+1];
  assign lit_o   = lit;
  assign inten_o = lit ? prod[31:16] : 16'd0;
  assign side_o  = side_q[S+1];
endmodule
`default_nettype wire

@@ hdl/point_light_angle_shading.sv @@
`default_nettype none
// Point-light shading: one transaction per cycle in and out, fully pipelined. Stages from
// input to output transaction: 5 front stages (difference, normalize, products, dot and
// cross sums, squared norm), 36 stages of the square-root of |n x d|^2, 16 CORDIC
// arctangent stages, one clamp stage and the output register. A stall on a valid
// output freezes the whole pipeline; the output register keeps the result until taken.
module point_light_angle_shading (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic signed [31:0] point_x_i,
  input  wire logic signed [31:0] point_y_i,
  input  wire logic signed [31:0] point_z_i,
  input  wire logic signed [15:0] normal_x_i,
  input  wire logic signed [15:0] normal_y_i,
  input  wire logic signed [15:0] normal_z_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             lit_o,
  output logic [15:0]      out_intensity_o,
  output logic [15:0]      out_red_o,
  output logic [15:0]      out_green_o,
  output logic [15:0]      out_blue_o
);
  logic signed [31:0] lx_q, ly_q, lz_q;
  logic [15:0] li_q, lr_q, lg_q, lb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lx_q <= '0; ly_q <= '0; lz_q <= '0;
      li_q <= 16'd4096; lr_q <= 16'd16384; lg_q <= 16'd16384; lb_q <= 16'd16384;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        plas_pkg::RegLightX: lx_q <= cfg_data_i;
        plas_pkg::RegLightY: ly_q <= cfg_data_i;
        plas_pkg::RegLightZ: lz_q <= cfg_data_i;
        plas_pkg::RegIntens: li_q <= cfg_data_i[15:0];
        plas_pkg::RegRed:    lr_q <= cfg_data_i[15:0];
        plas_pkg::RegGreen:  lg_q <= cfg_data_i[15:0];
        plas_pkg::RegBlue:   lb_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  logic en;
  logic out_vld_q;
  assign en = !(out_vld_q && out_stall_i);
  assign in_stall_o = !en;

  // stage 1: difference magnitudes
  logic        v1_q;
  logic [32:0] m1_q [3];
  logic [2:0]  n1_q;
  logic signed [15:0] nx1_q, ny1_q, nz1_q;
  plas_pkg::side_t s1_q;
  logic signed [33:0] dv [3];
  plas_pkg::side_t s0;
  always_comb begin
    dv[0] = 34'(lx_q) - 34'(point_x_i);
    dv[1] = 34'(ly_q) - 34'(point_y_i);
    dv[2] = 34'(lz_q) - 34'(point_z_i);
    s0 = '{zero: 1'b0, inten: li_q, red: lr_q, green: lg_q, blue: lb_q};
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        n1_q[i] <= dv[i][33];
        m1_q[i] <= dv[i][33] ? 33'(-dv[i]) : dv[i][32:0];
      end
      nx1_q <= normal_x_i; ny1_q <= normal_y_i; nz1_q <= normal_z_i;
      s1_q <= s0;
    end
  end

  // stage 2: normalize the largest magnitude to [2^14, 2^15)
  logic        v2_q;
  logic signed [16:0] d2_q [3];
  logic signed [15:0] nx2_q, ny2_q, nz2_q;
  plas_pkg::side_t s2_q;
  logic [32:0] mx;
  logic [5:0]  lead;
  logic [15:0] mg [3];
  always_comb begin
    mx = m1_q[0] | m1_q[1] | m1_q[2];
    lead = '0;
    for (int b = 0; b < 33; b++) if (mx[b]) lead = 6'(b);
    for (int i = 0; i < 3; i++) begin
      if (lead >= 6'd14) mg[i] = 16'(m1_q[i] >> (lead - 6'd14));
      else mg[i] = 16'(m1_q[i] << (6'd14 - lead));
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++)
        d2_q[i] <= n1_q[i] ? -$signed({1'b0, mg[i]}) : $signed({1'b0, mg[i]});
      nx2_q <= nx1_q; ny2_q <= ny1_q; nz2_q <= nz1_q;
      s2_q <= '{zero: (mx == '0), inten: s1_q.inten, red: s1_q.red,
                green: s1_q.green, blue: s1_q.blue};
    end
  end

  // stage 3: products
  logic v3_q;
  logic signed [32:0] p3_q [9];
  plas_pkg::side_t s3_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      p3_q[0] <= nx2_q * d2_q[0];
      p3_q[1] <= ny2_q * d2_q[1];
      p3_q[2] <= nz2_q * d2_q[2];
      p3_q[3] <= ny2_q * d2_q[2];
      p3_q[4] <= nz2_q * d2_q[1];
      p3_q[5] <= nz2_q * d2_q[0];
      p3_q[6] <= nx2_q * d2_q[2];
      p3_q[7] <= nx2_q * d2_q[1];
      p3_q[8] <= ny2_q * d2_q[0];
      s3_q <= s2_q;
    end
  end

  // stage 4: dot and cross
  logic v4_q;
  logic signed [35:0] x4_q;
  logic signed [34:0] c4_q [3];
  plas_pkg::side_t s4_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      x4_q <= 36'(p3_q[0]) + 36'(p3_q[1]) + 36'(p3_q[2]);
      c4_q[0] <= 35'(p3_q[3]) - 35'(p3_q[4]);
      c4_q[1] <= 35'(p3_q[5]) - 35'(p3_q[6]);
      c4_q[2] <= 35'(p3_q[7]) - 35'(p3_q[8]);
      s4_q <= s3_q;
    end
  end

  // stage 5: squared norm
  logic v5_q;
  logic signed [35:0] x5_q;
  logic [plas_pkg::SqW-1:0] sq5_q;
  plas_pkg::side_t s5_q;
  logic [69:0] sq [3];
  always_comb begin
    for (int i = 0; i < 3; i++) sq[i] = 70'($signed(c4_q[i]) * $signed(c4_q[i]));
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      sq5_q <= 72'(sq[0]) + 72'(sq[1]) + 72'(sq[2]);
      x5_q <= x4_q;
      s5_q <= s4_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0; v4_q <= 1'b0; v5_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i; v2_q <= v1_q; v3_q <= v2_q; v4_q <= v3_q; v5_q <= v4_q;
    end
  end

  logic sq_vld;
  logic [plas_pkg::RtW-1:0] root;
  logic signed [plas_pkg::XW-1:0] sq_x;
  plas_pkg::side_t sq_side;

  plas_isqrt u_isqrt (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v5_q), .val_i(sq5_q), .x_i(x5_q),
    .side_i(s5_q), .valid_o(sq_vld), .root_o(root), .x_o(sq_x), .side_o(sq_side)
  );

  logic cv;
  logic clit;
  logic [15:0] cint;
  plas_pkg::side_t cside;

  plas_cordic u_cordic (
    .clk_i, .rst_ni, .en_i(en), .valid_i(sq_vld), .x_i(sq_x), .y_i(root),
    .side_i(sq_side), .valid_o(cv), .lit_o(clit), .inten_o(cint), .side_o(cside)
  );

  logic lit_q;
  logic [15:0] oi_q, or_q, og_q, ob_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_vld_q <= 1'b0;
    else if (en) out_vld_q <= cv;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      lit_q <= clit; oi_q <= cint;
      or_q <= cside.red; og_q <= cside.green; ob_q <= cside.blue;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign lit_o           = lit_q;
  assign out_intensity_o = oi_q;
  assign out_red_o       = or_q;
  assign out_green_o     = og_q;
  assign out_blue_o      = ob_q;

`ifndef ASSERT_OFF
  a_unlit_dark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !lit_o |-> out_intensity_o == 16'd0) else $error("unlit with intensity");
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_intensity_o))
    else $error("stalled output changed");
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i) else $error("spurious input stall");
`endif
endmodule
`default_nettype wire
